### src/qptu_pkg.sv
// Shared constants, codes and types of the quintic position trajectory unit.
package qptu_pkg;

   // Defaults of the top-level parameters.
   localparam int POSITION_BITS_DEF = 32;
   localparam int FRACTION_BITS_DEF = 24;

   // Fixed field widths.
   localparam int POS_W     = 32;
   localparam int MOVE_W    = 24;
   localparam int DUR_W     = 32;
   localparam int ID_W      = 8;
   localparam int SPD_W     = 31;
   localparam int TPS_W     = 20;
   localparam int CSR_IDX_W = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_ID  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_SEC = 2'd2;

   // Register reset values.
   localparam logic [ID_W-1:0]  DRIVE_ID_RST  = '0;
   localparam logic [SPD_W-1:0] MAX_SPEED_RST = SPD_W'(100000);
   localparam logic [TPS_W-1:0] TICKS_SEC_RST = TPS_W'(1000);

   // Input item kinds.
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Datapath operations.
   typedef logic [4:0] op_type;
   localparam op_type OP_NONE        = 5'd0;
   localparam op_type OP_SET         = 5'd1;
   localparam op_type OP_TICK        = 5'd2;
   localparam op_type OP_LATCH       = 5'd3;
   localparam op_type OP_AUTO_MUL    = 5'd4;
   localparam op_type OP_DIV_AUTO    = 5'd5;
   localparam op_type OP_AUTO_FIX    = 5'd6;
   localparam op_type OP_DIV_FRAC    = 5'd7;
   localparam op_type OP_S           = 5'd8;
   localparam op_type OP_S2          = 5'd9;
   localparam op_type OP_S3          = 5'd10;
   localparam op_type OP_INNER       = 5'd11;
   localparam op_type OP_P           = 5'd12;
   localparam op_type OP_OFF         = 5'd13;
   localparam op_type OP_POS         = 5'd14;
   localparam op_type OP_COMMIT_NONE = 5'd15;
   localparam op_type OP_COMMIT_HOLD = 5'd16;
   localparam op_type OP_COMMIT_JUMP = 5'd17;
   localparam op_type OP_COMMIT_RAMP = 5'd18;

   // Datapath status seen by the controller.
   typedef struct packed {
      logic target_set;
      logic reached;
      logic ramp;
      logic pending;
      logic match;
      logic dur_zero;
      logic el_ge_dur;
      logic div_done;
   } dp_status_type;

endpackage

### src/qptu_div.sv
// Restoring divider, one quotient bit per cycle.
module qptu_div
   import qptu_pkg::*;
#(
   parameter int DW = 56,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   rem_sh;
   logic [VW:0]   diff;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[DW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = dividend;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
         quot_in = {quot_ff[DW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### src/qptu_dpath.sv
// Datapath: move state, configuration, shared multiplier, divider and result register.
module qptu_dpath
   import qptu_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic [POS_W-1:0]     target_position,
   input  logic                 use_trajectory,
   input  logic [MOVE_W-1:0]    move_duration,
   input  logic                 status_valid,
   input  logic [ID_W-1:0]      status_id,
   input  logic [POS_W-1:0]     measured_position,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPD_W-1:0]     csr_wdata,
   output dp_status_type        status,
   output logic [POS_W-1:0]     position_command,
   output logic                 on_target,
   output logic                 target_active
);

   localparam int PB      = POSITION_BITS;
   localparam int FB      = FRACTION_BITS;
   localparam int MAG_W   = PB + 1;
   localparam int AUTO_W  = MAG_W + TPS_W + 1;
   localparam int FRAC_W  = DUR_W + FB;
   localparam int DIV_W   = (AUTO_W > FRAC_W) ? AUTO_W : FRAC_W;
   localparam int IW      = FB + 4;
   localparam int MA      = (MAG_W > FB) ? MAG_W : FB;
   localparam int MB      = IW;
   localparam int PW      = MA + MB;
   localparam int OFF_W   = PB + 5;
   localparam logic [IW:0] TEN_Q  = (IW + 1)'(10) << FB;
   localparam logic [PW:0] HALF_Q = (PW + 1)'(1) << (FB - 1);

   // configuration
   logic [ID_W-1:0]  drive_id_ff, drive_id_in;
   logic [SPD_W-1:0] max_speed_ff, max_speed_in;
   logic [TPS_W-1:0] tps_ff, tps_in;
   // move state
   logic [PB-1:0]    held_ff, held_in;
   logic [PB-1:0]    start_ff, start_in;
   logic [PB:0]      dist_ff, dist_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic [DUR_W-1:0] el_ff, el_in;
   logic             ramp_ff, ramp_in;
   logic             pending_ff, pending_in;
   logic             reached_ff, reached_in;
   logic             tset_ff, tset_in;
   // per-tick work
   logic             match_ff, match_in;
   logic [PB-1:0]    meas_ff, meas_in;
   logic [AUTO_W-1:0] num_ff, num_in;
   logic [FB-1:0]    s_ff, s_in;
   logic [FB-1:0]    s2_ff, s2_in;
   logic [FB-1:0]    s3_ff, s3_in;
   logic [IW-1:0]    inner_ff, inner_in;
   logic [IW-1:0]    p_ff, p_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [PB-1:0]    pos_ff, pos_in;
   // result register
   logic [POS_W-1:0] out_pos_ff, out_pos_in;
   logic             out_on_ff, out_on_in;
   logic             out_act_ff, out_act_in;

   logic [MAG_W-1:0] mag;
   logic [SPD_W-1:0] spd;
   logic [MA-1:0]    mul_a;
   logic [MB-1:0]    mul_b;
   logic [PW-1:0]    prod;
   logic [PW:0]      prod_rnd;
   logic [IW:0]      s2e, se, inner_sum;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DUR_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic [DUR_W-1:0] auto_d;
   logic [DUR_W-1:0] el_inc;
   logic             running;
   logic             el_ge_dur;
   logic [PB-1:0]    ramp_pos;

   qptu_div #(
      .DW (DIV_W),
      .VW (DUR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      mag = dist_ff[PB] ? MAG_W'(-dist_ff) : MAG_W'(dist_ff);
      spd = (max_speed_ff == '0) ? SPD_W'(1) : max_speed_ff;

      // shared multiplier operand selection
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_AUTO_MUL: begin
            mul_a = MA'(mag);
            mul_b = MB'(tps_ff);
         end
         OP_S2: begin
            mul_a = MA'(s_ff);
            mul_b = MB'(s_ff);
         end
         OP_S3: begin
            mul_a = MA'(s2_ff);
            mul_b = MB'(s_ff);
         end
         OP_P: begin
            mul_a = MA'(s3_ff);
            mul_b = inner_ff;
         end
         OP_OFF: begin
            mul_a = MA'(mag);
            mul_b = p_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod     = PW'(mul_a) * PW'(mul_b);
      prod_rnd = {1'b0, prod} + HALF_Q;

      s2e       = (IW + 1)'(s2_ff);
      se        = (IW + 1)'(s_ff);
      inner_sum = TEN_Q + (s2e << 2) + (s2e << 1) - ((se << 4) - se);

      div_start    = (op == OP_DIV_AUTO) || (op == OP_DIV_FRAC);
      div_dividend = (op == OP_DIV_AUTO) ? DIV_W'(num_ff) : DIV_W'({el_ff, {FB{1'b0}}});
      div_divisor  = (op == OP_DIV_AUTO) ? DUR_W'(spd) : dur_ff;

      // saturate to 32 bits, floor at one second
      auto_d = (div_quot > DIV_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : div_quot[DUR_W-1:0];
      if (auto_d < DUR_W'(tps_ff)) begin
         auto_d = DUR_W'(tps_ff);
      end

      el_inc    = (el_ff == {DUR_W{1'b1}}) ? el_ff : el_ff + DUR_W'(1);
      running   = ramp_ff && !pending_ff && !reached_ff;
      el_ge_dur = el_ff >= dur_ff;
      ramp_pos  = el_ge_dur ? held_ff : pos_ff;

      drive_id_in  = drive_id_ff;
      max_speed_in = max_speed_ff;
      tps_in       = tps_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DRIVE_ID:  drive_id_in  = csr_wdata[ID_W-1:0];
            CSR_MAX_SPEED: max_speed_in = csr_wdata;
            CSR_TICKS_SEC: tps_in       = csr_wdata[TPS_W-1:0];
            default:       drive_id_in  = drive_id_ff;
         endcase
      end

      held_in    = held_ff;
      start_in   = start_ff;
      dist_in    = dist_ff;
      dur_in     = dur_ff;
      el_in      = el_ff;
      ramp_in    = ramp_ff;
      pending_in = pending_ff;
      reached_in = reached_ff;
      tset_in    = tset_ff;
      match_in   = match_ff;
      meas_in    = meas_ff;
      num_in     = num_ff;
      s_in       = s_ff;
      s2_in      = s2_ff;
      s3_in      = s3_ff;
      inner_in   = inner_ff;
      p_in       = p_ff;
      off_in     = off_ff;
      pos_in     = pos_ff;
      out_pos_in = out_pos_ff;
      out_on_in  = out_on_ff;
      out_act_in = out_act_ff;

      case (op)
         OP_SET: begin
            held_in    = target_position[PB-1:0];
            ramp_in    = use_trajectory;
            dur_in     = DUR_W'(move_duration);
            el_in      = '0;
            pending_in = 1'b1;
            reached_in = 1'b0;
            tset_in    = 1'b1;
         end
         OP_TICK: begin
            match_in = status_valid && (status_id == drive_id_ff);
            meas_in  = measured_position[PB-1:0];
         end
         OP_LATCH: begin
            dist_in    = {held_ff[PB-1], held_ff} - {meas_ff[PB-1], meas_ff};
            start_in   = meas_ff;
            el_in      = '0;
            pending_in = 1'b0;
         end
         OP_AUTO_MUL: num_in = AUTO_W'(prod) + AUTO_W'(spd >> 1);
         OP_AUTO_FIX: dur_in = auto_d;
         OP_S:        s_in = div_quot[FB-1:0];
         OP_S2:       s2_in = FB'(prod >> FB);
         OP_S3:       s3_in = FB'(prod >> FB);
         OP_INNER:    inner_in = inner_sum[IW-1:0];
         OP_P:        p_in = IW'(prod >> FB);
         OP_OFF:      off_in = OFF_W'(prod_rnd >> FB);
         OP_POS: begin
            pos_in = dist_ff[PB] ? start_ff - PB'(off_ff) : start_ff + PB'(off_ff);
         end
         OP_COMMIT_NONE: begin
            out_pos_in = '0;
            out_on_in  = 1'b0;
            out_act_in = 1'b0;
         end
         OP_COMMIT_HOLD: begin
            if (running) begin
               el_in = el_inc;
            end
            out_pos_in = POS_W'(held_ff);
            out_on_in  = reached_ff;
            out_act_in = 1'b1;
         end
         OP_COMMIT_JUMP: begin
            reached_in = 1'b1;
            out_pos_in = POS_W'(held_ff);
            out_on_in  = 1'b1;
            out_act_in = 1'b1;
         end
         OP_COMMIT_RAMP: begin
            reached_in = (ramp_pos == held_ff);
            el_in      = el_inc;
            out_pos_in = POS_W'(ramp_pos);
            out_on_in  = (ramp_pos == held_ff);
            out_act_in = 1'b1;
         end
         default: begin
            out_act_in = out_act_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_id_ff  <= DRIVE_ID_RST;
         max_speed_ff <= MAX_SPEED_RST;
         tps_ff       <= TICKS_SEC_RST;
         held_ff      <= '0;
         start_ff     <= '0;
         dist_ff      <= '0;
         dur_ff       <= '0;
         el_ff        <= '0;
         ramp_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         reached_ff   <= 1'b0;
         tset_ff      <= 1'b0;
      end else begin
         drive_id_ff  <= drive_id_in;
         max_speed_ff <= max_speed_in;
         tps_ff       <= tps_in;
         held_ff      <= held_in;
         start_ff     <= start_in;
         dist_ff      <= dist_in;
         dur_ff       <= dur_in;
         el_ff        <= el_in;
         ramp_ff      <= ramp_in;
         pending_ff   <= pending_in;
         reached_ff   <= reached_in;
         tset_ff      <= tset_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff   <= match_in;
      meas_ff    <= meas_in;
      num_ff     <= num_in;
      s_ff       <= s_in;
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      inner_ff   <= inner_in;
      p_ff       <= p_in;
      off_ff     <= off_in;
      pos_ff     <= pos_in;
      out_pos_ff <= out_pos_in;
      out_on_ff  <= out_on_in;
      out_act_ff <= out_act_in;
   end

   assign status.target_set = tset_ff;
   assign status.reached    = reached_ff;
   assign status.ramp       = ramp_ff;
   assign status.pending    = pending_ff;
   assign status.match      = match_ff;
   assign status.dur_zero   = (dur_ff == '0);
   assign status.el_ge_dur  = el_ge_dur;
   assign status.div_done   = div_done;

   assign position_command = out_pos_ff;
   assign on_target        = out_on_ff;
   assign target_active    = out_act_ff;

   a_reached_needs_target: assert property (@(posedge clock) disable iff (reset)
      reached_ff |-> tset_ff)
      else $error("on_target set without a target");

endmodule

### src/qptu_ctrl.sv
// Controller: sequences one item through the datapath and owns the result valid.
module qptu_ctrl
   import qptu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_command,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output op_type        op
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DECIDE    = 4'd1;
   localparam logic [3:0] ST_LATCHED   = 4'd2;
   localparam logic [3:0] ST_AUTO_DIV  = 4'd3;
   localparam logic [3:0] ST_AUTO_WAIT = 4'd4;
   localparam logic [3:0] ST_CHECK     = 4'd5;
   localparam logic [3:0] ST_FRAC_WAIT = 4'd6;
   localparam logic [3:0] ST_S2        = 4'd7;
   localparam logic [3:0] ST_S3        = 4'd8;
   localparam logic [3:0] ST_INNER     = 4'd9;
   localparam logic [3:0] ST_P         = 4'd10;
   localparam logic [3:0] ST_OFF       = 4'd11;
   localparam logic [3:0] ST_POS       = 4'd12;
   localparam logic [3:0] ST_COMMIT    = 4'd13;

   localparam logic [1:0] K_NONE = 2'd0;
   localparam logic [1:0] K_HOLD = 2'd1;
   localparam logic [1:0] K_JUMP = 2'd2;
   localparam logic [1:0] K_RAMP = 2'd3;

   logic [3:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op           = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op = (req_command == CMD_TICK) ? OP_TICK : OP_SET;
               if (req_command == CMD_TICK) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (!status.target_set) begin
               kind_in  = K_NONE;
               state_in = ST_COMMIT;
            end else if (status.reached || !status.match) begin
               kind_in  = K_HOLD;
               state_in = ST_COMMIT;
            end else if (!status.ramp) begin
               kind_in  = K_JUMP;
               state_in = ST_COMMIT;
            end else if (status.pending) begin
               op       = OP_LATCH;
               state_in = ST_LATCHED;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_LATCHED: begin
            if (status.dur_zero) begin
               op       = OP_AUTO_MUL;
               state_in = ST_AUTO_DIV;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_AUTO_DIV: begin
            op       = OP_DIV_AUTO;
            state_in = ST_AUTO_WAIT;
         end
         ST_AUTO_WAIT: begin
            if (status.div_done) begin
               op       = OP_AUTO_FIX;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            kind_in = K_RAMP;
            if (status.el_ge_dur) begin
               state_in = ST_COMMIT;
            end else begin
               op       = OP_DIV_FRAC;
               state_in = ST_FRAC_WAIT;
            end
         end
         ST_FRAC_WAIT: begin
            if (status.div_done) begin
               op       = OP_S;
               state_in = ST_S2;
            end
         end
         ST_S2: begin
            op       = OP_S2;
            state_in = ST_S3;
         end
         ST_S3: begin
            op       = OP_S3;
            state_in = ST_INNER;
         end
         ST_INNER: begin
            op       = OP_INNER;
            state_in = ST_P;
         end
         ST_P: begin
            op       = OP_P;
            state_in = ST_OFF;
         end
         ST_OFF: begin
            op       = OP_OFF;
            state_in = ST_POS;
         end
         ST_POS: begin
            op       = OP_POS;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               case (kind_ff)
                  K_NONE:  op = OP_COMMIT_NONE;
                  K_HOLD:  op = OP_COMMIT_HOLD;
                  K_JUMP:  op = OP_COMMIT_JUMP;
                  K_RAMP:  op = OP_COMMIT_RAMP;
                  default: op = OP_COMMIT_NONE;
               endcase
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= K_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && out_free) |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_commit_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && !out_free) |=> (state_ff == ST_COMMIT))
      else $error("commit left while result register busy");

   a_tick_decides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && req_command == CMD_TICK)
         |=> (state_ff == ST_DECIDE))
      else $error("accepted tick not sequenced");

endmodule

### src/quintic_position_trajectory_unit.sv
// Top level of the quintic point-to-point position trajectory unit.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | req_tuser command, req_tdata item fields
//  rsp     | out       | rsp_tvalid/rsp_tready  | rsp_tdata command, on_target, active
//  csr     | in        | csr_valid/csr_ready    | csr_index, csr_wdata
//
// A set_target transfer gives no result.
// When the ramp is evaluated, a tick's time is set by the shared restoring
// divider that yields one quotient bit a cycle; the first tick of an
// automatic-duration move runs it twice. Ticks that hold or jump go from the
// decision straight to the commit; a tick past the end time passes the end check first.
// Reset is synchronous; the csr port never stalls.
// A finished result waits in the output register while the next transfer is taken.
module quintic_position_trajectory_unit
   import qptu_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_tuser,   // command
   // target_position[31:0], use_trajectory[32], move_duration[56:33],
   // status_valid[57], status_id[65:58], measured_position[97:66]
   input  logic [103:0]         req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // position_command[31:0], on_target[32], target_active[33]
   output logic [39:0]          rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPD_W-1:0]     csr_wdata
);

   dp_status_type    status;
   op_type           op;
   logic [POS_W-1:0] position_command;
   logic             on_target;
   logic             target_active;

   // Configuration is always taken.
   assign csr_ready = 1'b1;

   qptu_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .op          (op)
   );

   qptu_dpath #(
      .POSITION_BITS (POSITION_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .target_position   (req_tdata[31:0]),
      .use_trajectory    (req_tdata[32]),
      .move_duration     (req_tdata[56:33]),
      .status_valid      (req_tdata[57]),
      .status_id         (req_tdata[65:58]),
      .measured_position (req_tdata[97:66]),
      .csr_write         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .status            (status),
      .position_command  (position_command),
      .on_target         (on_target),
      .target_active     (target_active)
   );

   // Pad the result to whole bytes.
   assign rsp_tdata = {6'b0, target_active, on_target, position_command};

endmodule
